[rtl/asma_pkg.sv]
// asma_pkg: shared constants and types for the accelerometer moving-average block.
// Depends on nothing; used by every module under rtl/.
package asma_pkg;

	// Window depth; must be a power of two (2..64)
	localparam int DEPTH      = 8;
	localparam int DEPTH_LOG2 = $clog2(DEPTH);
	localparam int SLOT_W     = DEPTH_LOG2;
	localparam int CNT_W      = DEPTH_LOG2 + 1;

	// Sample conversion: 12-bit reading * 10000, floor shift by 8
	localparam int RAW_W    = 12;
	localparam int SCALE    = 10000;
	localparam int FRAC_SH  = 8;
	localparam int PROD_W   = 26;
	localparam int SAMPLE_W = PROD_W - FRAC_SH;   // 18, covers -80000..79960
	localparam int SUM_W    = SAMPLE_W;           // mean never exceeds one sample's range

	localparam int OFF_W     = 21;
	localparam int OUT_W     = 22;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	// Action codes
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Sequencer to lane controls
	typedef struct packed {
		logic              clear;     // restart: drop running sum
		logic              load;      // capture raw bytes
		logic              rd;        // multiply, fetch oldest entry
		logic              upd;       // write ring, update running sum
		logic              have_old;  // ring full: oldest entry leaves the window
		logic [SLOT_W-1:0] slot;
	} lane_ctrl_t;

endpackage

[rtl/asma_lane.sv]
// asma_lane: one axis lane - scales a byte pair, keeps its ring and running window sum.
// Depends on asma_pkg.
module asma_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  asma_pkg::lane_ctrl_t                 ctrl,
	input  logic [7:0]                           lo,
	input  logic [7:0]                           hi,
	output logic signed [asma_pkg::SUM_W-1:0]    sum
);

	logic [7:0]                                lo_q;
	logic [7:0]                                hi_q;
	logic signed [asma_pkg::PROD_W-1:0]        prod_s1;
	logic signed [asma_pkg::SAMPLE_W-1:0]      old_s1;
	logic signed [asma_pkg::SUM_W-1:0]         sum_q;
	logic signed [asma_pkg::SAMPLE_W-1:0]      ring_mem [asma_pkg::DEPTH];

	logic signed [asma_pkg::RAW_W-1:0]         raw;
	logic signed [asma_pkg::PROD_W-1:0]        prod_c;
	logic signed [asma_pkg::SAMPLE_W-1:0]      scaled;
	logic signed [asma_pkg::SUM_W-1:0]         new_sh;
	logic signed [asma_pkg::SUM_W-1:0]         old_sh;

	// high byte signed * 16 plus top nibble of low byte
	assign raw    = {hi_q, lo_q[7:4]};
	assign prod_c = asma_pkg::PROD_W'(raw) * asma_pkg::PROD_W'(asma_pkg::SCALE);
	assign scaled = prod_s1[asma_pkg::PROD_W-1:asma_pkg::FRAC_SH];
	assign new_sh = asma_pkg::SUM_W'(scaled >>> asma_pkg::DEPTH_LOG2);
	assign old_sh = ctrl.have_old ? asma_pkg::SUM_W'(old_s1 >>> asma_pkg::DEPTH_LOG2)
	                              : '0;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lo_q <= lo;
			hi_q <= hi;
		end
		if (ctrl.rd) begin
			prod_s1 <= prod_c;
			old_s1  <= ring_mem[ctrl.slot];
		end
		if (ctrl.upd) begin
			ring_mem[ctrl.slot] <= scaled;
		end
	end

	// entries are only used once the ring has wrapped, so the ring needs no clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.upd) begin
			sum_q <= sum_q + new_sh - old_sh;
		end
	end

	assign sum = sum_q;

endmodule

[rtl/asma_merge.sv]
// asma_merge: combines the three lane sums with offsets into the output register.
// Depends on asma_pkg.
module asma_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic signed [asma_pkg::SUM_W-1:0]    sum_x,
	input  logic signed [asma_pkg::SUM_W-1:0]    sum_y,
	input  logic signed [asma_pkg::SUM_W-1:0]    sum_z,
	input  logic signed [asma_pkg::OFF_W-1:0]    off_x,
	input  logic signed [asma_pkg::OFF_W-1:0]    off_y,
	input  logic signed [asma_pkg::OFF_W-1:0]    off_z,
	output logic                                 can_load,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [asma_pkg::OUT_W-1:0]    out_x,
	output logic signed [asma_pkg::OUT_W-1:0]    out_y,
	output logic signed [asma_pkg::OUT_W-1:0]    out_z
);

	logic                                valid_q;
	logic signed [asma_pkg::OUT_W-1:0]   x_q;
	logic signed [asma_pkg::OUT_W-1:0]   y_q;
	logic signed [asma_pkg::OUT_W-1:0]   z_q;

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// X axis is mirrored on the board
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= -asma_pkg::OUT_W'(sum_x) - asma_pkg::OUT_W'(off_x);
			y_q <= asma_pkg::OUT_W'(sum_y) - asma_pkg::OUT_W'(off_y);
			z_q <= asma_pkg::OUT_W'(sum_z) - asma_pkg::OUT_W'(off_z);
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;

endmodule

[rtl/accel_sample_moving_average.sv]
// accel_sample_moving_average: top level of the accelerometer boxcar filter.
// Depends on asma_pkg, asma_lane, asma_merge.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid, in_ready, action, byte0..byte5      | in
//  output  | out_valid, out_ready, out_x, out_y, out_z     | out
//  config  | cfg_we, cfg_index, cfg_data                   | in
//
// A sample transaction holds the input side through capture at acceptance,
// multiply plus ring read, ring write plus running-sum update, and merge. Once
// the window is full, the result register loads at the end of the merge step,
// when the output register can take it. The ring memory's single port (read
// then write of the same slot) and the registered multiply separate the steps.
// A restart transaction completes in the cycle it is accepted. in_ready drops
// while a sample is in flight and while a finished result cannot enter a full,
// stalled output register; a result waiting at the output does not block
// acceptance of the next sample.
// Reset clears counters, running sums and offsets; ring contents are never
// cleared because an entry is only used after it has been rewritten.
module accel_sample_moving_average (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [7:0]                            byte0,
	input  logic [7:0]                            byte1,
	input  logic [7:0]                            byte2,
	input  logic [7:0]                            byte3,
	input  logic [7:0]                            byte4,
	input  logic [7:0]                            byte5,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [asma_pkg::OUT_W-1:0]     out_x,
	output logic signed [asma_pkg::OUT_W-1:0]     out_y,
	output logic signed [asma_pkg::OUT_W-1:0]     out_z,
	input  logic                                  cfg_we,
	input  logic [asma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [asma_pkg::OFF_W-1:0]            cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MERGE
	} state_t;

	state_t                              state_q;
	logic [asma_pkg::SLOT_W-1:0]         slot_q;
	logic [asma_pkg::CNT_W-1:0]          count_q;
	logic                                emit_q;
	logic signed [asma_pkg::OFF_W-1:0]   off_x_q;
	logic signed [asma_pkg::OFF_W-1:0]   off_y_q;
	logic signed [asma_pkg::OFF_W-1:0]   off_z_q;

	logic                                accept;
	logic                                full;
	logic                                can_load;
	logic                                merge_load;
	asma_pkg::lane_ctrl_t                ctrl;
	logic signed [asma_pkg::SUM_W-1:0]   sum_x;
	logic signed [asma_pkg::SUM_W-1:0]   sum_y;
	logic signed [asma_pkg::SUM_W-1:0]   sum_z;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign full       = (count_q == asma_pkg::CNT_W'(asma_pkg::DEPTH));
	assign merge_load = (state_q == ST_MERGE) && emit_q && can_load;

	always_comb begin
		ctrl          = '0;
		ctrl.clear    = accept && (action == asma_pkg::ACT_RESTART);
		ctrl.load     = accept && (action == asma_pkg::ACT_SAMPLE);
		ctrl.rd       = (state_q == ST_READ);
		ctrl.upd      = (state_q == ST_UPDATE);
		ctrl.have_old = full;
		ctrl.slot     = slot_q;
	end

	// sequencer: slot pointer, warm-up count, emit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			count_q <= '0;
			emit_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.clear) begin
						slot_q  <= '0;
						count_q <= '0;
					end else if (ctrl.load) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					slot_q  <= slot_q + 1'b1;   // power-of-two depth wraps naturally
					count_q <= full ? count_q : count_q + 1'b1;
					emit_q  <= (count_q >= asma_pkg::CNT_W'(asma_pkg::DEPTH - 1));
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (!emit_q || can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// offset registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				asma_pkg::REG_OFFSET_X: off_x_q <= cfg_data;
				asma_pkg::REG_OFFSET_Y: off_y_q <= cfg_data;
				asma_pkg::REG_OFFSET_Z: off_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// first pair feeds Y, second X, third Z
	asma_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.lo     (byte0),
		.hi     (byte1),
		.sum    (sum_y)
	);

	asma_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.lo     (byte2),
		.hi     (byte3),
		.sum    (sum_x)
	);

	asma_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.lo     (byte4),
		.hi     (byte5),
		.sum    (sum_z)
	);

	asma_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (merge_load),
		.sum_x     (sum_x),
		.sum_y     (sum_y),
		.sum_z     (sum_z),
		.off_x     (off_x_q),
		.off_y     (off_y_q),
		.off_z     (off_z_q),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z)
	);

endmodule

[rtl/asma_check.sv]
// asma_check: port-level checks for accel_sample_moving_average, bound to the top.
// Depends on asma_pkg and the top level's port list.
module asma_check (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic                                  action,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [asma_pkg::OUT_W-1:0]     out_x,
	input  logic signed [asma_pkg::OUT_W-1:0]     out_y,
	input  logic signed [asma_pkg::OUT_W-1:0]     out_z
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("stalled result changed");

	// a sample transaction occupies the input side
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == asma_pkg::ACT_SAMPLE) |=> !in_ready)
		else $error("input ready right after a sample");

	// a restart leaves the input ready in the next cycle
	a_restart_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == asma_pkg::ACT_RESTART) |=> in_ready)
		else $error("restart stalled the input");

	// a new result only follows an accepted sample
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && in_ready && (action == asma_pkg::ACT_SAMPLE), 4))
		else $error("result without a matching sample");

endmodule

bind accel_sample_moving_average asma_check u_asma_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.action    (action),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z)
);
